// ===== src/tsaf_pkg.sv =====
// Package for the transport stream adaptation field parser.
// Holds the queue entry and result types and the shared constants.
`timescale 1ns / 1ps
`default_nettype none

package tsaf_pkg;

    localparam logic [1:0] STATUS_PARSED      = 2'd0;
    localparam logic [1:0] STATUS_NO_FIELD    = 2'd1;
    localparam logic [1:0] STATUS_ZERO_LENGTH = 2'd2;

    localparam logic [7:0] POS_CONTROL      = 8'd3;
    localparam logic [7:0] POS_FIELD_LENGTH = 8'd4;
    localparam logic [7:0] POS_FIELD_FLAGS  = 8'd5;
    localparam logic [7:0] POS_FIRST_ITEM   = 8'd6;
    localparam logic [7:0] POS_SATURATE     = 8'd255;
    localparam logic [7:0] LAST_PACKET_BYTE = 8'd187;
    localparam logic [7:0] MAX_LENGTH_FIT   = 8'd183;
    localparam logic [8:0] POS_UNKNOWN      = 9'h1FF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] pos;
        logic       start;
    } t_tsaf_entry;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  field_length;
        logic [7:0]  field_flags;
        logic [41:0] pcr;
        logic [41:0] opcr;
        logic [7:0]  splice_countdown;
        logic [7:0]  private_length;
        logic [3:0]  extension_flags;
        logic [14:0] ltw_offset;
        logic [21:0] piecewise_rate;
        logic [3:0]  splice_type;
        logic [32:0] dts_next_unit;
    } t_tsaf_result;

endpackage

`default_nettype wire

// ===== src/tsaf_if.sv =====
// Valid/ready channel interfaces for the packet byte input and the result output.
// Standalone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

interface tsaf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       packet_start;

    modport source (output valid, output data_byte, output packet_start, input ready);
    modport sink (input valid, input data_byte, input packet_start, output ready);
endinterface

interface tsaf_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  field_length;
    logic [7:0]  field_flags;
    logic [41:0] pcr;
    logic [41:0] opcr;
    logic [7:0]  splice_countdown;
    logic [7:0]  private_length;
    logic [3:0]  extension_flags;
    logic [14:0] ltw_offset;
    logic [21:0] piecewise_rate;
    logic [3:0]  splice_type;
    logic [32:0] dts_next_unit;

    modport source (output valid, output status, output field_length, output field_flags,
                    output pcr, output opcr, output splice_countdown, output private_length,
                    output extension_flags, output ltw_offset, output piecewise_rate,
                    output splice_type, output dts_next_unit, input ready);
    modport sink (input valid, input status, input field_length, input field_flags,
                  input pcr, input opcr, input splice_countdown, input private_length,
                  input extension_flags, input ltw_offset, input piecewise_rate,
                  input splice_type, input dts_next_unit, output ready);
endinterface

`default_nettype wire

// ===== src/tsaf_front.sv =====
// Front end: accepts packet bytes and tags each word with its byte position.
// Depends on tsaf_pkg and tsaf_if.
`timescale 1ns / 1ps
`default_nettype none

module tsaf_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    tsaf_in_if.sink                   i_in,
    input  wire logic                 i_push_ready,
    output logic                      o_push,
    output tsaf_pkg::t_tsaf_entry     o_entry
);
    import tsaf_pkg::*;

    logic [7:0] r_byte_position;
    logic [7:0] n_byte_position;
    logic [7:0] w_pos;
    logic       w_accept;

    assign i_in.ready = i_push_ready;
    assign o_push     = i_in.valid;
    assign w_accept   = i_in.valid && i_push_ready;
    assign w_pos      = i_in.packet_start ? 8'd0 : r_byte_position;

    assign o_entry.data_byte = i_in.data_byte;
    assign o_entry.pos       = w_pos;
    assign o_entry.start     = i_in.packet_start;

    always_comb begin
        n_byte_position = r_byte_position;
        if (w_accept) begin
            n_byte_position = (w_pos == POS_SATURATE) ? POS_SATURATE : w_pos + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_position <= 8'd0;
        end else begin
            r_byte_position <= n_byte_position;
        end
    end

endmodule

`default_nettype wire

// ===== src/tsaf_fifo.sv =====
// Two-word queue between the front end and the field walker.
// Depends on tsaf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsaf_fifo (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire tsaf_pkg::t_tsaf_entry i_entry,
    output logic                      o_ready,
    input  wire logic                 i_pop,
    output logic                      o_valid,
    output tsaf_pkg::t_tsaf_entry     o_entry
);
    import tsaf_pkg::*;

    t_tsaf_entry r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        w_do_push;
    logic        w_do_pop;

    assign o_ready   = (r_count != 2'd2);
    assign o_valid   = (r_count != 2'd0);
    assign o_entry   = r_mem[r_rd_ptr];
    assign w_do_push = i_push && o_ready;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/tsaf_back.sv =====
// Back end: walks the adaptation field one word per cycle unless a held result stalls it, and registers the result.
// Depends on tsaf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsaf_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_entry_valid,
    input  wire tsaf_pkg::t_tsaf_entry i_entry,
    output logic                      o_entry_pop,
    input  wire logic                 i_result_ready,
    output logic                      o_result_valid,
    output tsaf_pkg::t_tsaf_result    o_result
);
    import tsaf_pkg::*;

    // The fifth byte of a clock reference keeps only its top and bottom bits.
    function automatic logic [41:0] clock_byte(input logic [41:0] acc, input logic [2:0] k,
                                               input logic [7:0] b);
        logic [41:0] res;
        if (k == 3'd4) begin
            res = {acc[39:0], b[7], b[0]};
        end else begin
            res = {acc[33:0], b};
        end
        return res;
    endfunction

    logic [7:0]   r_field_end, n_field_end;
    logic [7:0]   r_flags, n_flags;
    logic [8:0]   r_next_item, n_next_item;
    logic [41:0]  r_pcr, n_pcr;
    logic [41:0]  r_opcr, n_opcr;
    logic [63:0]  r_ext0, n_ext0;
    logic [47:0]  r_ext1, n_ext1;
    logic         r_emitted, n_emitted;
    logic         r_out_valid;
    t_tsaf_result r_result;
    t_tsaf_result w_result;

    logic [7:0]   w_pos;
    logic [7:0]   w_b;
    logic [7:0]   w_p1, w_p2, w_p3;
    logic [7:0]   w_after;
    logic [7:0]   w_pcr_k, w_opcr_k;
    logic [7:0]   w_ext_d;
    logic [7:0]   w_xf;
    logic [7:0]   w_qa, w_qb;
    logic         w_emit;
    logic [1:0]   w_status;
    logic [39:0]  w_ss;

    assign w_pos    = i_entry.pos;
    assign w_b      = i_entry.data_byte;
    assign w_p1     = POS_FIRST_ITEM + (r_flags[4] ? 8'd6 : 8'd0);
    assign w_p2     = w_p1 + (r_flags[3] ? 8'd6 : 8'd0);
    assign w_p3     = w_p2 + {7'd0, r_flags[2]};
    assign w_after  = POS_FIRST_ITEM + (w_b[4] ? 8'd6 : 8'd0) + (w_b[3] ? 8'd6 : 8'd0)
                    + {7'd0, w_b[2]};
    assign w_pcr_k  = w_pos - POS_FIRST_ITEM;
    assign w_opcr_k = w_pos - w_p1;
    assign w_ext_d  = w_pos - r_next_item[7:0];
    assign w_xf     = r_ext0[23:16];
    assign w_qa     = 8'd2 + (w_xf[7] ? 8'd2 : 8'd0);
    assign w_qb     = w_qa + (w_xf[6] ? 8'd3 : 8'd0);

    always_comb begin
        n_field_end = r_field_end;
        n_flags     = r_flags;
        n_next_item = r_next_item;
        n_pcr       = r_pcr;
        n_opcr      = r_opcr;
        n_ext0      = r_ext0;
        n_ext1      = r_ext1;
        n_emitted   = r_emitted;
        w_emit      = 1'b0;
        w_status    = STATUS_PARSED;
        if (i_entry.start) begin
            n_field_end = 8'd0;
            n_flags     = 8'd0;
            n_next_item = 9'd0;
            n_pcr       = 42'd0;
            n_opcr      = 42'd0;
            n_ext0      = 64'd0;
            n_ext1      = 48'd0;
            n_emitted   = 1'b0;
        end else if (!r_emitted) begin
            if (w_pos == POS_CONTROL) begin
                n_flags = {6'd0, w_b[5:4]};
            end else if (w_pos == POS_FIELD_LENGTH) begin
                if (!r_flags[1]) begin
                    w_emit   = 1'b1;
                    w_status = STATUS_NO_FIELD;
                end else if (w_b == 8'd0) begin
                    w_emit   = 1'b1;
                    w_status = STATUS_ZERO_LENGTH;
                end else begin
                    n_ext1[47:40] = w_b;
                    n_field_end   = (w_b > MAX_LENGTH_FIT) ? LAST_PACKET_BYTE
                                                           : w_b + POS_FIELD_LENGTH;
                    n_flags       = 8'd0;
                end
            end else if (w_pos >= POS_FIELD_FLAGS && r_field_end != 8'd0
                         && w_pos <= r_field_end) begin
                if (w_pos == POS_FIELD_FLAGS) begin
                    n_flags     = w_b;
                    n_next_item = w_b[1] ? POS_UNKNOWN : {1'b0, w_after};
                end else if (r_flags[4] && w_pos < w_p1) begin
                    n_pcr = clock_byte(r_pcr, w_pcr_k[2:0], w_b);
                end else if (r_flags[3] && w_pos < w_p2) begin
                    n_opcr = clock_byte(r_opcr, w_opcr_k[2:0], w_b);
                end else if (r_flags[2] && w_pos == w_p2) begin
                    n_ext0[7:0] = w_b;
                end else if (r_flags[1] && w_pos == w_p3) begin
                    n_ext0[15:8] = w_b;
                    n_next_item  = {1'b0, w_p3} + 9'd1 + {1'b0, w_b};
                end else if (r_flags[0] && r_next_item != POS_UNKNOWN
                             && {1'b0, w_pos} >= r_next_item) begin
                    if (w_ext_d == 8'd1) begin
                        n_ext0[23:16] = w_b;
                    end else if (w_ext_d == 8'd0) begin
                        n_ext0 = r_ext0;
                    end else if (w_xf[7] && w_ext_d < w_qa) begin
                        n_ext0[39:24] = {r_ext0[31:24], w_b};
                    end else if (w_xf[6] && w_ext_d < w_qb) begin
                        n_ext0[63:40] = {r_ext0[55:40], w_b};
                    end else if (w_xf[5] && w_ext_d < w_qb + 8'd5) begin
                        n_ext1[39:0] = {r_ext1[31:0], w_b};
                    end
                end
                if (w_pos == r_field_end) begin
                    w_emit   = 1'b1;
                    w_status = STATUS_PARSED;
                end
            end
            if (w_emit) begin
                n_emitted = 1'b1;
            end
        end
    end

    assign w_ss = n_ext1[39:0];

    always_comb begin
        w_result.status           = w_status;
        w_result.field_length     = n_ext1[47:40];
        w_result.field_flags      = (w_status == STATUS_PARSED) ? n_flags : 8'd0;
        w_result.pcr              = n_pcr;
        w_result.opcr             = n_opcr;
        w_result.splice_countdown = n_ext0[7:0];
        w_result.private_length   = n_ext0[15:8];
        w_result.extension_flags  = {n_ext0[23], n_ext0[22], n_ext0[21], n_ext0[39]};
        w_result.ltw_offset       = n_ext0[38:24];
        w_result.piecewise_rate   = n_ext0[61:40];
        w_result.splice_type      = w_ss[39:36];
        w_result.dts_next_unit    = {w_ss[35:33], w_ss[31:24], w_ss[23:17], w_ss[15:8],
                                     w_ss[7:1]};
    end

    assign o_entry_pop    = i_entry_valid && (!w_emit || !r_out_valid || i_result_ready);
    assign o_result_valid = r_out_valid;
    assign o_result       = r_result;

    always_ff @(posedge i_clk) begin
        if (o_entry_pop && w_emit) begin
            r_result <= w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_end <= 8'd0;
            r_flags     <= 8'd0;
            r_next_item <= 9'd0;
            r_pcr       <= 42'd0;
            r_opcr      <= 42'd0;
            r_ext0      <= 64'd0;
            r_ext1      <= 48'd0;
            r_emitted   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_entry_pop) begin
                r_field_end <= n_field_end;
                r_flags     <= n_flags;
                r_next_item <= n_next_item;
                r_pcr       <= n_pcr;
                r_opcr      <= n_opcr;
                r_ext0      <= n_ext0;
                r_ext1      <= n_ext1;
                r_emitted   <= n_emitted;
            end
            if (o_entry_pop && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_result_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/ts_adaptation_field_parser.sv =====
// Top level of the transport stream adaptation field parser.
// Takes one packet byte per cycle while the queue has room; bytes are queued, results registered.
// The byte tagger, the two-word queue and the field walker each run one word per cycle unless the output stalls.
// A result held at the output stalls the walker only when the next byte also produces a result.
// Synchronous active-low reset clears byte position, field state, the queue and the result valid flag.
// Depends on tsaf_pkg, tsaf_if, tsaf_front, tsaf_fifo and tsaf_back.
`timescale 1ns / 1ps
`default_nettype none

module ts_adaptation_field_parser (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tsaf_in_if.sink   i_in,
    tsaf_out_if.source o_out
);
    import tsaf_pkg::*;

    t_tsaf_entry  w_push_entry;
    t_tsaf_entry  w_pop_entry;
    logic         w_push;
    logic         w_push_ready;
    logic         w_pop;
    logic         w_pop_valid;
    logic         w_result_valid;
    t_tsaf_result w_result;

    tsaf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_push_ready (w_push_ready),
        .o_push       (w_push),
        .o_entry      (w_push_entry)
    );

    tsaf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_ready (w_push_ready),
        .i_pop   (w_pop),
        .o_valid (w_pop_valid),
        .o_entry (w_pop_entry)
    );

    tsaf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_entry_valid  (w_pop_valid),
        .i_entry        (w_pop_entry),
        .o_entry_pop    (w_pop),
        .i_result_ready (o_out.ready),
        .o_result_valid (w_result_valid),
        .o_result       (w_result)
    );

    assign o_out.valid            = w_result_valid;
    assign o_out.status           = w_result.status;
    assign o_out.field_length     = w_result.field_length;
    assign o_out.field_flags      = w_result.field_flags;
    assign o_out.pcr              = w_result.pcr;
    assign o_out.opcr             = w_result.opcr;
    assign o_out.splice_countdown = w_result.splice_countdown;
    assign o_out.private_length   = w_result.private_length;
    assign o_out.extension_flags  = w_result.extension_flags;
    assign o_out.ltw_offset       = w_result.ltw_offset;
    assign o_out.piecewise_rate   = w_result.piecewise_rate;
    assign o_out.splice_type      = w_result.splice_type;
    assign o_out.dts_next_unit    = w_result.dts_next_unit;

endmodule

`default_nettype wire
